// ===== src/dpts_pkg.sv =====
`timescale 1ns / 1ps

package dpts_pkg;

   localparam int MAX_TASKS_DEF = 16;
   localparam int NAME_W        = 8;
   localparam int PRI_W         = 8;
   localparam int RT_W          = 16;
   localparam int INDEX_W       = 4;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   typedef struct packed {
      logic [NAME_W-1:0] name;
      logic [PRI_W-1:0]  pri;
      logic [RT_W-1:0]   remaining;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic               load_accepted;
      logic               ran_valid;
      logic [INDEX_W-1:0] ran_index;
      logic [NAME_W-1:0]  ran_name;
      logic [PRI_W-1:0]   ran_new_priority;
      logic [RT_W-1:0]    ran_remaining;
      logic               ran_finished;
      logic               all_finished;
   } rsp_payload_type;

endpackage

// ===== src/dpts_req_if.sv =====
`timescale 1ns / 1ps

interface dpts_req_if
   import dpts_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [NAME_W-1:0] task_name;
   logic [PRI_W-1:0]  task_priority;
   logic [RT_W-1:0]   task_runtime;

   modport source (output valid, output req_type, output task_name,
                   output task_priority, output task_runtime, input ready);
   modport sink   (input valid, input req_type, input task_name,
                   input task_priority, input task_runtime, output ready);
endinterface

// ===== src/dpts_rsp_if.sv =====
`timescale 1ns / 1ps

interface dpts_rsp_if
   import dpts_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               load_accepted;
   logic               ran_valid;
   logic [INDEX_W-1:0] ran_index;
   logic [NAME_W-1:0]  ran_name;
   logic [PRI_W-1:0]   ran_new_priority;
   logic [RT_W-1:0]    ran_remaining;
   logic               ran_finished;
   logic               all_finished;

   modport source (output valid, output load_accepted, output ran_valid,
                   output ran_index, output ran_name, output ran_new_priority,
                   output ran_remaining, output ran_finished,
                   output all_finished, input ready);
   modport sink   (input valid, input load_accepted, input ran_valid,
                   input ran_index, input ran_name, input ran_new_priority,
                   input ran_remaining, input ran_finished,
                   input all_finished, output ready);
endinterface

// ===== src/dpts_ram.sv =====
`timescale 1ns / 1ps

module dpts_ram
   import dpts_pkg::*;
#(
   parameter int WIDTH = ENTRY_W,
   parameter int DEPTH = MAX_TASKS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/dynamic_priority_tick_scheduler.sv =====
`timescale 1ns / 1ps
// Tick scheduler over a table of up to MAX_TASKS tasks (name, priority, run time).
// req_bus: one beat per item. req_type selects a load (append a task, refused
// when the table is full) or a tick (run the ready task of highest priority,
// lowest slot on a tie, then age its priority (not below zero) and run time by one).
// rsp_bus: exactly one beat per request beat, in order.
// A load answers from ST_LOAD; a tick answers from ST_FINISH after ST_SCAN
// and ST_DRAIN, since the task table sits in one RAM read port and the scan
// compares one slot per cycle against the running best.
// A new beat is taken only once the previous result is registered, so no
// request is taken before the block is through with the last one.
// The result register holds one beat. If the receiver stalls, the next item is
// still taken and worked, and then holds in its last step until the register
// frees; req_bus.ready stays low meanwhile.
// Reset (synchronous, active high) empties the table: no task ready, no slot
// used, no result pending. Table contents are not cleared; only ready slots are
// ever chosen by a tick.
module dynamic_priority_tick_scheduler
   import dpts_pkg::*;
#(
   parameter int MAX_TASKS = MAX_TASKS_DEF
) (
   input logic      clock,
   input logic      reset,
   dpts_req_if.sink   req_bus,
   dpts_rsp_if.source rsp_bus
);

   localparam int IDX_W = $clog2(MAX_TASKS);
   localparam int CNT_W = $clog2(MAX_TASKS + 1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LOAD   = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [NAME_W-1:0] name_ff, name_in;
   logic [PRI_W-1:0]  pri_ff, pri_in;
   logic [RT_W-1:0]   rt_ff, rt_in;
   logic [IDX_W-1:0]  scan_idx_ff, scan_idx_in;
   logic              cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [NAME_W-1:0] best_name_ff, best_name_in;
   logic [PRI_W-1:0]  best_pri_ff, best_pri_in;
   logic [RT_W-1:0]   best_rem_ff, best_rem_in;
   logic [MAX_TASKS-1:0] ready_ff, ready_in;
   logic [CNT_W-1:0]  ready_cnt_ff, ready_cnt_in;
   logic [CNT_W-1:0]  entry_cnt_ff, entry_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_data_ff, rsp_data_in;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_entry;
   logic [ENTRY_W-1:0] rd_data;
   entry_type          rd_entry;
   logic               out_free;
   logic               take;
   logic [PRI_W-1:0]   new_pri;
   logic [RT_W-1:0]    new_rem;
   logic [IDX_W+INDEX_W-1:0] idx_ext;

   dpts_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_TASKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_data)
   );

   assign rd_entry = entry_type'(rd_data);
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign take     = cmp_valid_ff && ready_ff[cmp_idx_ff]
                     && (!found_ff || (rd_entry.pri > best_pri_ff));
   assign new_pri  = (best_pri_ff == '0) ? best_pri_ff : best_pri_ff - PRI_W'(1);
   assign new_rem  = best_rem_ff - RT_W'(1);
   assign idx_ext  = (IDX_W + INDEX_W)'(best_idx_ff);

   assign req_bus.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      name_in      = name_ff;
      pri_in       = pri_ff;
      rt_in        = rt_ff;
      scan_idx_in  = scan_idx_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = scan_idx_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_name_in = best_name_ff;
      best_pri_in  = best_pri_ff;
      best_rem_in  = best_rem_ff;
      ready_in     = ready_ff;
      ready_cnt_in = ready_cnt_ff;
      entry_cnt_in = entry_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = best_idx_ff;
      wr_entry     = '{name: best_name_ff, pri: new_pri, remaining: new_rem};

      // fold the slot read last cycle into the running best
      if (take) begin
         found_in     = 1'b1;
         best_idx_in  = cmp_idx_ff;
         best_name_in = rd_entry.name;
         best_pri_in  = rd_entry.pri;
         best_rem_in  = rd_entry.remaining;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               name_in     = req_bus.task_name;
               pri_in      = req_bus.task_priority;
               rt_in       = req_bus.task_runtime;
               scan_idx_in = '0;
               found_in    = 1'b0;
               state_in    = (req_bus.req_type == REQ_LOAD) ? ST_LOAD : ST_SCAN;
            end
         end
         ST_LOAD: begin
            if (out_free) begin
               rsp_data_in = '0;
               if (entry_cnt_ff < CNT_W'(MAX_TASKS)) begin
                  wr_en    = 1'b1;
                  wr_addr  = entry_cnt_ff[IDX_W-1:0];
                  wr_entry = '{name: name_ff, pri: pri_ff, remaining: rt_ff};
                  entry_cnt_in = entry_cnt_ff + CNT_W'(1);
                  if (rt_ff != '0) begin
                     ready_in[entry_cnt_ff[IDX_W-1:0]] = 1'b1;
                     ready_cnt_in = ready_cnt_ff + CNT_W'(1);
                  end
                  rsp_data_in.load_accepted = 1'b1;
               end
               rsp_data_in.all_finished = (ready_cnt_in == '0);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SCAN: begin
            cmp_valid_in = 1'b1;
            scan_idx_in  = scan_idx_ff + IDX_W'(1);
            if (scan_idx_ff == IDX_W'(MAX_TASKS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_data_in = '0;
               if (found_ff) begin
                  wr_en = 1'b1;
                  rsp_data_in.ran_valid        = 1'b1;
                  rsp_data_in.ran_index        = idx_ext[INDEX_W-1:0];
                  rsp_data_in.ran_name         = best_name_ff;
                  rsp_data_in.ran_new_priority = new_pri;
                  rsp_data_in.ran_remaining    = new_rem;
                  if (new_rem == '0) begin
                     ready_in[best_idx_ff] = 1'b0;
                     ready_cnt_in = ready_cnt_ff - CNT_W'(1);
                     rsp_data_in.ran_finished = 1'b1;
                  end
               end
               rsp_data_in.all_finished = (ready_cnt_in == '0);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         ready_ff     <= '0;
         ready_cnt_ff <= '0;
         entry_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_valid_ff <= cmp_valid_in;
         found_ff     <= found_in;
         ready_ff     <= ready_in;
         ready_cnt_ff <= ready_cnt_in;
         entry_cnt_ff <= entry_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      name_ff      <= name_in;
      pri_ff       <= pri_in;
      rt_ff        <= rt_in;
      scan_idx_ff  <= scan_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      best_idx_ff  <= best_idx_in;
      best_name_ff <= best_name_in;
      best_pri_ff  <= best_pri_in;
      best_rem_ff  <= best_rem_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.load_accepted    = rsp_data_ff.load_accepted;
   assign rsp_bus.ran_valid        = rsp_data_ff.ran_valid;
   assign rsp_bus.ran_index        = rsp_data_ff.ran_index;
   assign rsp_bus.ran_name         = rsp_data_ff.ran_name;
   assign rsp_bus.ran_new_priority = rsp_data_ff.ran_new_priority;
   assign rsp_bus.ran_remaining    = rsp_data_ff.ran_remaining;
   assign rsp_bus.ran_finished     = rsp_data_ff.ran_finished;
   assign rsp_bus.all_finished     = rsp_data_ff.all_finished;

   a_ready_count: assert property (@(posedge clock) disable iff (reset)
      $countones(ready_ff) == int'(ready_cnt_ff))
      else $error("ready count out of step with ready bits");

   a_ready_le_entries: assert property (@(posedge clock) disable iff (reset)
      ready_cnt_ff <= entry_cnt_ff)
      else $error("more ready tasks than loaded slots");

   a_entry_bound: assert property (@(posedge clock) disable iff (reset)
      entry_cnt_ff <= CNT_W'(MAX_TASKS))
      else $error("slot count beyond table size");

   a_winner_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) && found_ff |-> ready_ff[best_idx_ff])
      else $error("selected task is not ready");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready |=> rsp_valid_ff)
      else $error("stalled result dropped");

endmodule

// ===== sim/dynamic_priority_tick_scheduler_tb.sv =====
`timescale 1ns / 1ps

module dynamic_priority_tick_scheduler_tb;
   import dpts_pkg::*;

   localparam int MAX_TASKS   = MAX_TASKS_DEF;
   localparam int IDLE_PCT    = 34;
   localparam int HOLD_CYCLES = 300;
   localparam int ITEM_TARGET = 1250;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [NAME_W-1:0] NAME_R = "R";
   localparam logic [NAME_W-1:0] NAME_E = "E";

   logic clock = 1'b0;
   logic reset = 1'b1;

   dpts_req_if req_bus ();
   dpts_rsp_if rsp_bus ();

   dynamic_priority_tick_scheduler #(.MAX_TASKS(MAX_TASKS)) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // scheduler state as predicted from accepted beats
   logic [NAME_W-1:0]    slot_name [MAX_TASKS];
   logic [PRI_W-1:0]     slot_pri  [MAX_TASKS];
   logic [RT_W-1:0]      slot_left [MAX_TASKS];
   logic [MAX_TASKS-1:0] slot_ready = '0;
   int                   slot_count = 0;

   rsp_payload_type pending_outcomes[$];

   int   mismatches    = 0;
   int   cycle_count   = 0;
   int   n_loaded      = 0;
   int   n_refused     = 0;
   int   n_ran         = 0;
   int   n_idle_ticks  = 0;
   logic steady_flow   = 1'b0;
   logic rsp_holding   = 1'b0;
   event hold_trigger;

   always #6 clock = ~clock;

   function automatic rsp_payload_type predict_outcome(input logic kind,
         input logic [NAME_W-1:0] nm, input logic [PRI_W-1:0] pr,
         input logic [RT_W-1:0] rt);
      rsp_payload_type o;
      int best;
      bit found;
      o = '0;
      best = 0;
      found = 1'b0;
      if (kind == REQ_LOAD) begin
         if (slot_count < MAX_TASKS) begin
            slot_name[slot_count]  = nm;
            slot_pri[slot_count]   = pr;
            slot_left[slot_count]  = rt;
            slot_ready[slot_count] = (rt != '0);
            slot_count++;
            o.load_accepted = 1'b1;
         end
      end else begin
         for (int i = 0; i < MAX_TASKS; i++) begin
            if (slot_ready[i] && (!found || slot_pri[i] > slot_pri[best])) begin
               best = i;
               found = 1'b1;
            end
         end
         if (found) begin
            if (slot_pri[best] != '0)
               slot_pri[best] = slot_pri[best] - 1'b1;
            slot_left[best] = slot_left[best] - 1'b1;
            if (slot_left[best] == '0) begin
               slot_ready[best] = 1'b0;
               o.ran_finished = 1'b1;
            end
            o.ran_valid        = 1'b1;
            o.ran_index        = INDEX_W'(best);
            o.ran_name         = slot_name[best];
            o.ran_new_priority = slot_pri[best];
            o.ran_remaining    = slot_left[best];
         end
      end
      o.all_finished = (slot_ready == '0);
      return o;
   endfunction

   task automatic send_request(input logic kind, input logic [NAME_W-1:0] nm,
         input logic [PRI_W-1:0] pr, input logic [RT_W-1:0] rt);
      rsp_payload_type outcome;
      while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.req_type      <= kind;
      req_bus.task_name     <= nm;
      req_bus.task_priority <= pr;
      req_bus.task_runtime  <= rt;
      do @(posedge clock); while (!req_bus.ready);
      outcome = predict_outcome(kind, nm, pr, rt);
      pending_outcomes.insert(pending_outcomes.size(), outcome);
      if (kind == REQ_LOAD) begin
         if (outcome.load_accepted) n_loaded++;
         else n_refused++;
      end else begin
         if (outcome.ran_valid) n_ran++;
         else n_idle_ticks++;
      end
      @(negedge clock);
   endtask

   task automatic send_random_request();
      logic [PRI_W-1:0] pr;
      logic [RT_W-1:0]  rt;
      int               load_pct;
      load_pct = (slot_count < MAX_TASKS) ? 20 : 4;
      if ($urandom_range(99) < load_pct) begin
         pr = $urandom_range(1) ? PRI_W'($urandom_range(3)) : PRI_W'($urandom_range(255));
         if (slot_count >= MAX_TASKS)
            rt = RT_W'($urandom_range(65535));
         else if ($urandom_range(9) == 0)
            rt = '0;
         else
            rt = RT_W'($urandom_range(160, 1));
         send_request(REQ_LOAD, NAME_W'($urandom_range(255)), pr, rt);
      end else begin
         send_request(REQ_TICK, NAME_W'($urandom()), PRI_W'($urandom()),
                      RT_W'($urandom()));
      end
   endtask

   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      while (pending_outcomes.size() != 0)
         @(negedge clock);
   endtask

   task automatic test_empty_table();
      send_request(REQ_TICK, 8'h00, 8'h00, 16'h0000);
      send_request(REQ_LOAD, 8'h00, 8'h00, 16'h0000);
      send_request(REQ_TICK, 8'hFF, 8'hFF, 16'hFFFF);
      wait_for_results();
   endtask

   task automatic test_ties_and_aging();
      send_request(REQ_LOAD, 8'hFF, 8'hFF, 16'd3);
      send_request(REQ_LOAD, NAME_R, 8'hFF, 16'd1);
      send_request(REQ_LOAD, NAME_E, 8'h00, 16'd2);
      repeat (7) send_request(REQ_TICK, 8'h00, 8'h00, 16'h0000);
      wait_for_results();
   endtask

   task automatic test_receiver_hold();
      -> hold_trigger;
      send_request(REQ_LOAD, 8'h5A, 8'h80, 16'd40);
      repeat (10) send_request(REQ_TICK, 8'h00, 8'h00, 16'h0000);
      wait_for_results();
   endtask

   task automatic test_steady_stream();
      steady_flow = 1'b1;
      repeat (100) send_random_request();
      steady_flow = 1'b0;
      wait_for_results();
   endtask

   task automatic test_random_schedule();
      while (n_loaded + n_refused + n_ran + n_idle_ticks < ITEM_TARGET)
         send_random_request();
      wait_for_results();
   endtask

   task automatic test_table_full();
      while (slot_count < MAX_TASKS)
         send_request(REQ_LOAD, NAME_W'($urandom_range(255)),
                      PRI_W'($urandom_range(255)), RT_W'($urandom_range(20, 1)));
      send_request(REQ_LOAD, 8'hFF, 8'hFF, 16'hFFFF);
      send_request(REQ_LOAD, 8'h00, 8'h00, 16'h0000);
      repeat (60) send_random_request();
      wait_for_results();
   endtask

   // receiver: random stalls, plus a long hold when triggered
   always @(negedge clock) begin
      if (reset || rsp_holding)
         rsp_bus.ready <= 1'b0;
      else if (steady_flow)
         rsp_bus.ready <= 1'b1;
      else
         rsp_bus.ready <= ($urandom_range(99) >= IDLE_PCT);
   end

   always begin
      @(hold_trigger);
      rsp_holding = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_holding = 1'b0;
   end

   task automatic check_field(input string fname, input logic [31:0] want,
         input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", fname, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : result_check
      rsp_payload_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            $error("result beat with no outstanding request");
            mismatches++;
         end else begin
            want = pending_outcomes.pop_front();
            check_field("load_accepted", want.load_accepted, rsp_bus.load_accepted);
            check_field("ran_valid", want.ran_valid, rsp_bus.ran_valid);
            check_field("ran_index", want.ran_index, rsp_bus.ran_index);
            check_field("ran_name", want.ran_name, rsp_bus.ran_name);
            check_field("ran_new_priority", want.ran_new_priority,
                        rsp_bus.ran_new_priority);
            check_field("ran_remaining", want.ran_remaining, rsp_bus.ran_remaining);
            check_field("ran_finished", want.ran_finished, rsp_bus.ran_finished);
            check_field("all_finished", want.all_finished, rsp_bus.all_finished);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      req_bus.valid         = 1'b0;
      req_bus.req_type      = REQ_LOAD;
      req_bus.task_name     = '0;
      req_bus.task_priority = '0;
      req_bus.task_runtime  = '0;
      rsp_bus.ready         = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_table();
      test_ties_and_aging();
      test_receiver_hold();
      test_steady_stream();
      test_random_schedule();
      test_table_full();

      repeat (MAX_TASKS + 3 + 10) @(posedge clock);
      $display("covered %0d stored loads, %0d refused loads, %0d ticks that ran a task,",
               n_loaded, n_refused, n_ran);
      $display("%0d ticks with nothing ready, under random stalls and a long hold",
               n_idle_ticks);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
src/dpts_pkg.sv
src/dpts_req_if.sv
src/dpts_rsp_if.sv
src/dpts_ram.sv
src/dynamic_priority_tick_scheduler.sv
sim/dynamic_priority_tick_scheduler_tb.sv
